/* rtl/lwhc_pkg.sv */
`timescale 1ns / 1ps

package lwhc_pkg;

  // Operation codes of the input request
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Configuration register indexes
  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] REG_LOOKAHEAD  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_HEAD_GAIN  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_P_GAIN     = 3'd2;
  localparam logic [CFG_IW-1:0] REG_D_GAIN     = 3'd3;
  localparam logic [CFG_IW-1:0] REG_TORQUE_LIM = 3'd4;
  localparam logic [CFG_IW-1:0] REG_SW_RADIUS  = 3'd5;
  localparam logic [CFG_IW-1:0] REG_THRUST     = 3'd6;
  localparam logic [CFG_IW-1:0] REG_WP_COUNT   = 3'd7;
  localparam int CFG_DW = 31;

  // CORDIC datapath
  localparam int XW    = 40;
  localparam int ZW    = 21;
  localparam int STEPS = 16;
  localparam int HALF_PI_Q16 = 102944;
  localparam int PI_Q16      = 205887;
  localparam int GAIN_Q16    = 39797;
  localparam int ARC_TAB [STEPS] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                     256, 128, 64, 32, 16, 8, 4, 2};

  // Angle constants, Q3.12
  localparam int PI_Q12     = 12868;
  localparam int TWO_PI_Q12 = 25736;
  localparam int PHI_LIM    = 2867;

  typedef struct packed {
    logic start;
    logic vectoring;
  } lwhc_cordic_cmd_t;

endpackage

/* rtl/lwhc_if.sv */
`timescale 1ns / 1ps

interface lwhc_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] heading;
  logic signed [15:0] rudder_angle;
  logic signed [15:0] rudder_rate;
  logic [5:0]         load_index;
  logic signed [31:0] load_x;
  logic signed [31:0] load_y;

  modport source (output valid, operation, pos_x, pos_y, heading, rudder_angle,
                  rudder_rate, load_index, load_x, load_y, input ready);
  modport sink (input valid, operation, pos_x, pos_y, heading, rudder_angle,
                rudder_rate, load_index, load_x, load_y, output ready);
endinterface

interface lwhc_out_if;
  logic               valid;
  logic               ready;
  logic [30:0]        thrust;
  logic signed [31:0] torque;
  logic [5:0]         active_target;

  modport source (output valid, thrust, torque, active_target, input ready);
  modport sink (input valid, thrust, torque, active_target, output ready);
endinterface

/* rtl/los_waypoint_heading_controller_core.sv */
`timescale 1ns / 1ps
// Line-of-sight waypoint guidance with a PD rudder-torque law.
//
// Channels: in_req carries requests; operation selects a control tick or a
// waypoint load. A load writes one slot of the waypoint RAM in the cycle it
// is taken and gives no result. A tick gives exactly one result on out_res
// (thrust, torque, active target index). cfg_we/cfg_index/cfg_wdata write
// the eight configuration registers; write them only while the block idles.
// A load is written in the cycle it is taken. A tick with fewer than two
// waypoints goes straight to the final step and the output register; a
// full tick runs three passes of one shared 16-step CORDIC unit (path
// angle, sin/cos, line-of-sight angle) plus the RAM reads, multiplies and
// up to two heading wrap steps. Any wait for out_res to drain lengthens it.
// One request is in work at a time; in_req.ready is high only when idle.
// The result sits in an output register, so a new request is taken while
// an earlier result still waits; a tick then holds its result until
// out_res drains.
// Reset: synchronous, active low; registers return to their defaults, the
// target index goes to one, the waypoint RAM keeps no defined contents.
module los_waypoint_heading_controller_core
  import lwhc_pkg::*;
#(
  parameter int MAX_WAYPOINTS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  lwhc_in_if.sink           in_req,
  lwhc_out_if.source        out_res,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int AW   = $clog2(MAX_WAYPOINTS);
  localparam int NLIM = (MAX_WAYPOINTS < 64) ? MAX_WAYPOINTS : 64;

  typedef enum logic [4:0] {
    S_IDLE, S_RD0, S_RD1, S_GAM_GO, S_GAM_WAIT, S_SC_GO, S_SC_WAIT,
    S_MUL_X, S_MUL_Y, S_XTE, S_LOS_GO, S_LOS_WAIT, S_WRAP, S_HEAD,
    S_TAU_P, S_TAU_D, S_TAU, S_SQ_X, S_SQ_Y, S_SQ_R, S_SW, S_FIN
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [30:0] lookahead_r, torque_lim_r, sw_radius_r, thrust_cmd_r;
  logic [15:0] head_gain_r, p_gain_r, d_gain_r;
  logic [6:0]  wp_count_r;

  // Guidance state
  logic [5:0]  target_r;
  logic [6:0]  n_r;
  logic        short_r;

  // Latched tick inputs and waypoints
  logic signed [31:0] px_r, py_r, x0_r, y0_r, x1_r, y1_r;
  logic signed [15:0] hd_r, ra_r, rr_r;

  // Datapath registers
  logic signed [16:0] gam_r;
  logic signed [17:0] sn_r, cs_r;
  logic signed [50:0] prod_x_r, prod_y_r;
  logic signed [35:0] e_r;
  logic signed [17:0] diff_r;
  logic signed [12:0] tphi_r;
  logic signed [33:0] p_prod_r;
  logic signed [32:0] d_prod_r;
  logic signed [31:0] tau_r;
  logic [61:0]        sqx_r, sqy_r, r2_r;
  logic               far_r;

  // Output register
  logic               out_valid_r;
  logic [30:0]        out_thrust_r;
  logic signed [31:0] out_torque_r;
  logic [5:0]         out_target_r;

  // Waypoint RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_rdata;
  logic [15:0]   ld_ext, rd_ext;

  // CORDIC unit
  lwhc_cordic_cmd_t     cmd;
  logic signed [XW-1:0] c_x_in, c_y_in, c_x_out, c_y_out;
  logic signed [ZW-1:0] c_z_in, c_z_out;
  logic                 c_done;

  logic in_acc, out_free;
  logic [6:0] n_eff;
  logic [5:0] t_eff;
  logic signed [34:0] hprod, hsh, tsum, tsh, lim;
  logic signed [32:0] ex, ey;
  logic signed [33:0] ddx;
  logic [33:0]        adx;
  logic signed [16:0] perr;
  logic signed [16:0] z_round;
  logic [62:0]        dsum;

  assign in_acc   = in_req.valid && in_req.ready;
  assign out_free = !out_valid_r || out_res.ready;
  assign in_req.ready = (state_r == S_IDLE);

  // Effective waypoint count and target pulled into the valid range
  always_comb begin
    n_eff = (int'(wp_count_r) > NLIM) ? 7'(NLIM) : wp_count_r;
    t_eff = target_r;
    if ({1'b0, t_eff} >= n_eff) begin
      t_eff = 6'(n_eff - 7'd1);
    end
    if (t_eff == '0) begin
      t_eff = 6'd1;
    end
  end

  assign ld_ext    = 16'(in_req.load_index);
  assign ram_we    = in_acc && (in_req.operation == OP_LOAD)
                     && (int'(in_req.load_index) < MAX_WAYPOINTS);
  assign ram_waddr = ld_ext[AW-1:0];
  // Issue previous waypoint read on accept, target read in the cycle after
  assign rd_ext    = (state_r == S_IDLE) ? 16'(t_eff - 6'd1) : 16'(target_r);
  assign ram_raddr = rd_ext[AW-1:0];

  lwhc_ram #(.WIDTH(64), .DEPTH(MAX_WAYPOINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({in_req.load_x, in_req.load_y}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // CORDIC operand select
  always_comb begin
    cmd.start     = (state_r == S_GAM_GO) || (state_r == S_SC_GO) || (state_r == S_LOS_GO);
    cmd.vectoring = (state_r != S_SC_GO);
    c_x_in = '0;
    c_y_in = '0;
    c_z_in = ZW'({gam_r, 4'b0000});
    if (state_r == S_GAM_GO) begin
      c_x_in = XW'(y1_r) - XW'(y0_r);
      c_y_in = XW'(x1_r) - XW'(x0_r);
    end else if (state_r == S_LOS_GO) begin
      c_x_in = XW'(lookahead_r);
      c_y_in = -XW'(e_r);
    end
  end

  lwhc_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .x_in  (c_x_in),
    .y_in  (c_y_in),
    .z_in  (c_z_in),
    .done  (c_done),
    .x_out (c_x_out),
    .y_out (c_y_out),
    .z_out (c_z_out)
  );

  // Round rad*2^16 to Q3.12
  assign z_round = 17'((c_z_out + ZW'(8)) >>> 4);

  assign ex    = 33'(px_r) - 33'(x0_r);
  assign ey    = 33'(py_r) - 33'(y0_r);
  assign hprod = diff_r * $signed({1'b0, head_gain_r});
  assign hsh   = hprod >>> 8;
  assign perr  = 17'(tphi_r) - 17'(ra_r);
  assign tsum  = 35'(p_prod_r) - 35'(d_prod_r);
  assign tsh   = tsum >>> 4;
  assign lim   = 35'(torque_lim_r);
  assign ddx   = (state_r == S_SQ_X) ? (34'(x1_r) - 34'(px_r)) : (34'(y1_r) - 34'(py_r));
  assign adx   = (ddx < 0) ? 34'(-ddx) : 34'(ddx);
  assign dsum  = 63'(sqx_r) + 63'(sqy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      target_r     <= 6'd1;
      out_valid_r  <= 1'b0;
      lookahead_r  <= 31'd65536;
      head_gain_r  <= 16'd256;
      p_gain_r     <= 16'd256;
      d_gain_r     <= 16'd0;
      torque_lim_r <= 31'd65536;
      sw_radius_r  <= 31'd65536;
      thrust_cmd_r <= 31'd0;
      wp_count_r   <= 7'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LOOKAHEAD:  lookahead_r  <= cfg_wdata;
          REG_HEAD_GAIN:  head_gain_r  <= cfg_wdata[15:0];
          REG_P_GAIN:     p_gain_r     <= cfg_wdata[15:0];
          REG_D_GAIN:     d_gain_r     <= cfg_wdata[15:0];
          REG_TORQUE_LIM: torque_lim_r <= cfg_wdata;
          REG_SW_RADIUS:  sw_radius_r  <= cfg_wdata;
          REG_THRUST:     thrust_cmd_r <= cfg_wdata;
          REG_WP_COUNT:   wp_count_r   <= cfg_wdata[6:0];
          default: ;
        endcase
      end

      // Drop the result once taken, unless the final step refills it
      if (out_valid_r && out_res.ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc && (in_req.operation == OP_TICK)) begin
            px_r    <= in_req.pos_x;
            py_r    <= in_req.pos_y;
            hd_r    <= in_req.heading;
            ra_r    <= in_req.rudder_angle;
            rr_r    <= in_req.rudder_rate;
            n_r     <= n_eff;
            short_r <= (n_eff < 7'd2);
            if (n_eff < 7'd2) begin
              state_r <= S_FIN;
            end else begin
              target_r <= t_eff;
              state_r  <= S_RD0;
            end
          end
        end
        S_RD0: begin
          x0_r    <= ram_rdata[63:32];
          y0_r    <= ram_rdata[31:0];
          state_r <= S_RD1;
        end
        S_RD1: begin
          x1_r    <= ram_rdata[63:32];
          y1_r    <= ram_rdata[31:0];
          state_r <= S_GAM_GO;
        end
        S_GAM_GO: state_r <= S_GAM_WAIT;
        S_GAM_WAIT: begin
          if (c_done) begin
            gam_r   <= z_round;
            state_r <= S_SC_GO;
          end
        end
        S_SC_GO: state_r <= S_SC_WAIT;
        S_SC_WAIT: begin
          if (c_done) begin
            sn_r    <= 18'(c_y_out);
            cs_r    <= 18'(c_x_out);
            state_r <= S_MUL_X;
          end
        end
        S_MUL_X: begin
          prod_x_r <= ex * cs_r;
          state_r  <= S_MUL_Y;
        end
        S_MUL_Y: begin
          prod_y_r <= ey * sn_r;
          state_r  <= S_XTE;
        end
        S_XTE: begin
          e_r     <= 36'((prod_x_r - prod_y_r) >>> 16);
          state_r <= S_LOS_GO;
        end
        S_LOS_GO: state_r <= S_LOS_WAIT;
        S_LOS_WAIT: begin
          if (c_done) begin
            diff_r  <= 18'(gam_r) + 18'(z_round) - 18'(hd_r);
            state_r <= S_WRAP;
          end
        end
        S_WRAP: begin
          // One 2*pi correction a cycle until inside +-pi
          if (diff_r > 18'(PI_Q12)) begin
            diff_r <= diff_r - 18'(TWO_PI_Q12);
          end else if (diff_r < -18'(PI_Q12)) begin
            diff_r <= diff_r + 18'(TWO_PI_Q12);
          end else begin
            state_r <= S_HEAD;
          end
        end
        S_HEAD: begin
          if (hsh > 35'(PHI_LIM)) begin
            tphi_r <= 13'(PHI_LIM);
          end else if (hsh < -35'(PHI_LIM)) begin
            tphi_r <= -13'(PHI_LIM);
          end else begin
            tphi_r <= 13'(hsh);
          end
          state_r <= S_TAU_P;
        end
        S_TAU_P: begin
          p_prod_r <= perr * $signed({1'b0, p_gain_r});
          state_r  <= S_TAU_D;
        end
        S_TAU_D: begin
          d_prod_r <= rr_r * $signed({1'b0, d_gain_r});
          state_r  <= S_TAU;
        end
        S_TAU: begin
          if (tsh > lim) begin
            tau_r <= 32'(lim);
          end else if (tsh < -lim) begin
            tau_r <= 32'(-lim);
          end else begin
            tau_r <= 32'(tsh);
          end
          state_r <= S_SQ_X;
        end
        S_SQ_X: begin
          far_r   <= adx[33:31] != '0;
          sqx_r   <= adx[30:0] * adx[30:0];
          state_r <= S_SQ_Y;
        end
        S_SQ_Y: begin
          far_r   <= far_r || (adx[33:31] != '0);
          sqy_r   <= adx[30:0] * adx[30:0];
          state_r <= S_SQ_R;
        end
        S_SQ_R: begin
          r2_r    <= sw_radius_r * sw_radius_r;
          state_r <= S_SW;
        end
        S_SW: begin
          // Advance inside the switch radius unless on the last waypoint
          if (!far_r && (dsum < 63'(r2_r)) && ({1'b0, target_r} < n_r - 7'd1)) begin
            target_r <= target_r + 6'd1;
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_thrust_r <= short_r ? 31'd0 : thrust_cmd_r;
            out_torque_r <= short_r ? 32'sd0 : tau_r;
            out_target_r <= target_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.thrust        = out_thrust_r;
  assign out_res.torque        = out_torque_r;
  assign out_res.active_target = out_target_r;

  // A new result only ever comes out of the final step
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside final step");

  // The target never points at the first waypoint
  a_target_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    target_r != 6'd0)
    else $error("target index is zero");

  // CORDIC completes only while a wait step expects it
  a_cordic_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    c_done |-> (state_r == S_GAM_WAIT || state_r == S_SC_WAIT || state_r == S_LOS_WAIT))
    else $error("unexpected CORDIC completion");

endmodule

/* rtl/lwhc_ram.sv */
`timescale 1ns / 1ps

module lwhc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/lwhc_cordic.sv */
`timescale 1ns / 1ps

module lwhc_cordic
  import lwhc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  lwhc_cordic_cmd_t        cmd,
  input  logic signed [XW-1:0]    x_in,
  input  logic signed [XW-1:0]    y_in,
  input  logic signed [ZW-1:0]    z_in,
  output logic                    done,
  output logic signed [XW-1:0]    x_out,
  output logic signed [XW-1:0]    y_out,
  output logic signed [ZW-1:0]    z_out
);

  logic                 busy_r;
  logic                 done_r;
  logic                 vec_r;
  logic                 neg_r;
  logic [3:0]           iter_r;
  logic signed [XW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;

  logic signed [XW-1:0] x0, y0;
  logic signed [ZW-1:0] z0;
  logic                 neg0;
  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] arc;
  logic                 pos;

  // Pre-rotation into the convergence range
  always_comb begin
    x0   = x_in;
    y0   = y_in;
    z0   = '0;
    neg0 = 1'b0;
    if (cmd.vectoring) begin
      if (x_in < 0) begin
        if (y_in >= 0) begin
          x0 = y_in;
          y0 = -x_in;
          z0 = ZW'(HALF_PI_Q16);
        end else begin
          x0 = -y_in;
          y0 = x_in;
          z0 = -ZW'(HALF_PI_Q16);
        end
      end
    end else begin
      x0 = XW'(GAIN_Q16);
      y0 = '0;
      z0 = z_in;
      if (z_in > ZW'(HALF_PI_Q16)) begin
        z0   = z_in - ZW'(PI_Q16);
        neg0 = 1'b1;
      end else if (z_in < -ZW'(HALF_PI_Q16)) begin
        z0   = z_in + ZW'(PI_Q16);
        neg0 = 1'b1;
      end
    end
  end

  assign xs  = x_r >>> iter_r;
  assign ys  = y_r >>> iter_r;
  assign arc = ZW'(ARC_TAB[iter_r]);
  assign pos = vec_r ? (y_r > 0) : (z_r < 0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        iter_r <= '0;
        vec_r  <= cmd.vectoring;
        neg_r  <= neg0;
        x_r    <= x0;
        y_r    <= y0;
        z_r    <= z0;
      end else if (busy_r) begin
        if (pos) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + arc;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - arc;
        end
        iter_r <= iter_r + 4'd1;
        if (iter_r == 4'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign x_out = neg_r ? -x_r : x_r;
  assign y_out = neg_r ? -y_r : y_r;
  assign z_out = z_r;

endmodule
